@@ rtl/hrld_pkg.sv @@
package hrld_pkg;

   localparam int SectorDegrees = 60;
   localparam int FullCode      = 255;
   localparam int SectorCount   = 8;            // hue/60 reaches 8 for a 9-bit hue
   localparam int Stages        = 5;            // register stages in the converter pipeline

   // reciprocal of 15 for the slope: (vs >> 3) * Slope15Mul >> Slope15Shift == vs / 120
   localparam int Slope15Mul   = 8739;
   localparam int Slope15Shift = 17;

   typedef enum logic {
      CMD_RGB = 1'b0,
      CMD_HSV = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      SEC_R_TO_Y = 3'd0,
      SEC_Y_TO_G = 3'd1,
      SEC_G_TO_C = 3'd2,
      SEC_C_TO_B = 3'd3,
      SEC_B_TO_M = 3'd4,
      SEC_M_TO_R = 3'd5
   } sector_type;

   typedef struct packed {
      cmd_type                cmd;
      sector_type             sector;
      logic [5:0]             pos;
      logic [15:0]            vs;
      logic [15:0]            bottom;
      logic [15:0]            top;
      logic [9:0]             slope;
      logic [15:0]            ramp;
      logic [2:0][15:0]       chan;
      logic [2:0][7:0]        rgb;
   } pipe_type;

   function automatic logic [7:0] clamp_level(input logic signed [15:0] x);
      logic [7:0] res;
      if (x[15]) begin
         res = 8'd0;
      end else if (|x[14:8]) begin
         res = 8'(FullCode);
      end else begin
         res = x[7:0];
      end
      return res;
   endfunction

   // number of whole 60-degree steps in the hue, 0..8
   function automatic logic [3:0] hue_steps(input logic [8:0] hue);
      logic [3:0] n;
      n = 4'd0;
      for (int k = 1; k <= SectorCount; k++) begin
         if (hue >= 9'(k * SectorDegrees)) begin
            n = 4'(k);
         end
      end
      return n;
   endfunction

   // exact x / 255 for x up to 65025: one correction on x >> 8
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [8:0] rem;
      logic [7:0] q;
      q   = x[15:8];
      rem = {1'b0, x[7:0]} + {1'b0, q};
      if (rem >= 9'(FullCode)) begin
         q = q + 8'd1;
      end
      return q;
   endfunction

endpackage

@@ rtl/hsv_to_rgb_led_duty.sv @@
// LED duty converter: each request word is a direct RGB color (command 0, three signed
// levels clamped to 0..255) or an HSV color (command 1) and gives one response word of
// three 8-bit PWM duty codes, duty fraction = code/255. The block is a five-stage pipeline
// (sector split and V*S products, slope by reciprocal multiply, slope*offset product, ramp
// select, divide by 255) and takes one word every cycle while the response side does not
// stall. Each stage holds its word while the stage after it is full and cannot pass its word
// on, so back-pressure never drops or repeats a word. Hue 360 and above uses the magenta-to-red
// sector formulas. There is no state and no configuration.
module hsv_to_rgb_led_duty (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  logic signed [15:0]  req_red_in,
   input  logic signed [15:0]  req_green_in,
   input  logic signed [15:0]  req_blue_in,
   input  logic [8:0]          req_hue,
   input  logic [7:0]          req_brightness,
   input  logic [7:0]          req_saturation,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_red_duty,
   output logic [7:0]          rsp_green_duty,
   output logic [7:0]          rsp_blue_duty
);
   import hrld_pkg::*;

   // per-stage valid bits and the words they qualify
   logic [Stages-1:0] valid_ff;
   logic [Stages-1:0] valid_in;
   logic [Stages-1:0] ready;
   pipe_type          s1_ff, s2_ff, s3_ff, s4_ff;
   pipe_type          s1_in, s2_in, s3_in, s4_in;
   logic [2:0][7:0]   duty_ff, duty_in;

   // a stage can take a word when it is empty or its word moves on this cycle
   always_comb begin
      ready[Stages-1] = !valid_ff[Stages-1] || rsp_ready;
      for (int i = Stages - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   assign req_ready = ready[0];

   always_comb begin
      valid_in[0] = req_valid;
      for (int i = 1; i < Stages; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   // stage 1: rgb clamp, hue sector and offset, V*S, bottom and top
   logic [3:0] steps;
   logic [9:0] steps_deg;
   logic [7:0] inv_sat;

   always_comb begin
      steps     = hue_steps(req_hue);
      steps_deg = 10'(steps) * 10'(SectorDegrees);
      inv_sat   = 8'(FullCode) - req_saturation;

      s1_in        = s2_ff;         // unused fields carry whatever
      s1_in.cmd    = cmd_type'(req_command);
      if (steps >= 4'(SEC_M_TO_R)) begin
         s1_in.sector = SEC_M_TO_R;  // hue 300 and up, including 360 and beyond
      end else begin
         s1_in.sector = sector_type'(steps[2:0]);
      end
      s1_in.pos    = 6'({1'b0, req_hue} - steps_deg);
      s1_in.vs     = req_brightness * req_saturation;
      s1_in.bottom = req_brightness * inv_sat;
      s1_in.top    = req_brightness * 8'(FullCode);
      s1_in.rgb[0] = clamp_level(req_red_in);
      s1_in.rgb[1] = clamp_level(req_green_in);
      s1_in.rgb[2] = clamp_level(req_blue_in);
   end

   // stage 2: slope = V*S / 120, as (V*S >> 3) / 15 by reciprocal
   logic [12:0] vs_div8;
   logic [26:0] slope_prod;

   always_comb begin
      vs_div8     = s1_ff.vs[15:3];
      slope_prod  = vs_div8 * 14'(Slope15Mul);
      s2_in       = s1_ff;
      s2_in.slope = slope_prod[Slope15Shift +: 10];
   end

   // stage 3: ramp = slope * offset within the sector
   always_comb begin
      s3_in      = s2_ff;
      s3_in.ramp = 16'(s2_ff.slope) * 16'(s2_ff.pos);
   end

   // stage 4: build the four ramps and route them per sector
   logic [15:0] half;
   logic [15:0] ramp_a, ramp_b, ramp_c, ramp_d;

   always_comb begin
      half   = {1'b0, s3_ff.vs[15:1]};
      // all ramps stay inside 0..65025, so 16 bits hold them
      ramp_a = s3_ff.bottom + s3_ff.ramp;
      ramp_b = s3_ff.bottom + half + s3_ff.ramp;
      ramp_c = s3_ff.top - s3_ff.ramp;
      ramp_d = s3_ff.top - half - s3_ff.ramp;

      s4_in = s3_ff;
      case (s3_ff.sector)
         SEC_R_TO_Y: s4_in.chan = {s3_ff.bottom, ramp_a, ramp_c};
         SEC_Y_TO_G: s4_in.chan = {s3_ff.bottom, ramp_b, ramp_d};
         SEC_G_TO_C: s4_in.chan = {ramp_a, ramp_c, s3_ff.bottom};
         SEC_C_TO_B: s4_in.chan = {ramp_b, ramp_d, s3_ff.bottom};
         SEC_B_TO_M: s4_in.chan = {ramp_c, s3_ff.bottom, ramp_a};
         default:    s4_in.chan = {ramp_d, s3_ff.bottom, ramp_b};
      endcase
   end

   // stage 5: scale each channel by 1/255, or pass the clamped rgb levels
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (s4_ff.cmd == CMD_HSV) begin
            duty_in[c] = div255(s4_ff.chan[c]);
         end else begin
            duty_in[c] = s4_ff.rgb[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < Stages; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         s1_ff <= s1_in;
      end
      if (ready[1]) begin
         s2_ff <= s2_in;
      end
      if (ready[2]) begin
         s3_ff <= s3_in;
      end
      if (ready[3]) begin
         s4_ff <= s4_in;
      end
      if (ready[4]) begin
         duty_ff <= duty_in;
      end
   end

   assign rsp_valid      = valid_ff[Stages-1];
   assign rsp_red_duty   = duty_ff[0];
   assign rsp_green_duty = duty_ff[1];
   assign rsp_blue_duty  = duty_ff[2];

   // reciprocal slope matches an exact divide by 120
   a_slope_exact: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] |-> (17'(s2_ff.slope) * 17'd120 <= {1'b0, s2_ff.vs}) &&
                      ({1'b0, s2_ff.vs} < 17'(s2_ff.slope) * 17'd120 + 17'd120))
      else $error("slope is not V*S/120");

   // selected hsv channels never exceed 255*255
   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] && s4_ff.cmd == CMD_HSV |->
         s4_ff.chan[0] <= 16'(FullCode * FullCode) &&
         s4_ff.chan[1] <= 16'(FullCode * FullCode) &&
         s4_ff.chan[2] <= 16'(FullCode * FullCode))
      else $error("hsv channel out of range");

   // an accepted request word lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted word lost at stage one");

   // a full stage whose successor is blocked keeps its word
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] && !ready[3] |=> valid_ff[2] && $stable(s3_ff))
      else $error("stalled word changed in the pipeline");

endmodule

@@ test/hsv_to_rgb_led_duty_tb.sv @@
`timescale 1ns / 100ps

module hsv_to_rgb_led_duty_tb;
   import hrld_pkg::*;

   localparam int SlopeDivisor = 2 * SectorDegrees;   // 120
   localparam int CycleLimit   = 200000;
   localparam int DrainCycles  = 20;
   localparam int HoldCycles   = 80;
   localparam int MaxReports   = 10;

   // one color command as offered on the request side
   typedef struct {
      cmd_type            command;
      logic signed [15:0] red;
      logic signed [15:0] green;
      logic signed [15:0] blue;
      logic [8:0]         hue;
      logic [7:0]         value;
      logic [7:0]         sat;
   } color_word_type;

   // three duty codes as returned on the response side
   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } duty_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_command = 1'b0;
   logic signed [15:0] req_red_in = '0;
   logic signed [15:0] req_green_in = '0;
   logic signed [15:0] req_blue_in = '0;
   logic [8:0]         req_hue = '0;
   logic [7:0]         req_brightness = '0;
   logic [7:0]         req_saturation = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_red_duty;
   logic [7:0]         rsp_green_duty;
   logic [7:0]         rsp_blue_duty;

   color_word_type pending_color_q[$];
   duty_type       expected_duty_q[$];
   int             mismatch_count = 0;
   int             cycle_count = 0;

   // idle percentages per phase, written by the stimulus block
   int          phase = 1;
   int          send_idle_pct = 30;
   int          recv_idle_pct = 72;

   hsv_to_rgb_led_duty DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_red_in     (req_red_in),
      .req_green_in   (req_green_in),
      .req_blue_in    (req_blue_in),
      .req_hue        (req_hue),
      .req_brightness (req_brightness),
      .req_saturation (req_saturation),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red_duty   (rsp_red_duty),
      .rsp_green_duty (rsp_green_duty),
      .rsp_blue_duty  (rsp_blue_duty)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // duty code prediction
   // ---------------------------------------------------------------------------------------

   // negative levels go dark, anything past full scale saturates
   function automatic logic [7:0] saturate_level(input logic signed [15:0] level);
      logic [7:0] code;
      if (level < 0) begin
         code = 8'd0;
      end else if (level > FullCode) begin
         code = 8'(FullCode);
      end else begin
         code = level[7:0];
      end
      return code;
   endfunction

   function automatic duty_type predict_duty(input color_word_type w);
      duty_type    d;
      sector_type  sec;
      int unsigned v, s, steps, pos, top, bottom, vs, slope, half, ramp;
      int unsigned ra, rb, rc, rd, cr, cg, cb;
      if (w.command == CMD_RGB) begin
         d.red   = saturate_level(w.red);
         d.green = saturate_level(w.green);
         d.blue  = saturate_level(w.blue);
      end else begin
         v      = w.value;
         s      = w.sat;
         steps  = w.hue / SectorDegrees;
         pos    = w.hue - steps * SectorDegrees;
         top    = v * FullCode;
         bottom = v * (FullCode - s);
         vs     = v * s;
         slope  = vs / SlopeDivisor;
         half   = vs / 2;
         ramp   = slope * pos;
         ra     = bottom + ramp;
         rb     = bottom + half + ramp;
         rc     = top - ramp;
         rd     = top - half - ramp;
         // hue 360 and beyond keeps the magenta-to-red formulas
         sec = (steps > 5) ? SEC_M_TO_R : sector_type'(steps[2:0]);
         case (sec)
            SEC_R_TO_Y: begin cr = rc;     cg = ra;     cb = bottom; end
            SEC_Y_TO_G: begin cr = rd;     cg = rb;     cb = bottom; end
            SEC_G_TO_C: begin cr = bottom; cg = rc;     cb = ra;     end
            SEC_C_TO_B: begin cr = bottom; cg = rd;     cb = rb;     end
            SEC_B_TO_M: begin cr = ra;     cg = bottom; cb = rc;     end
            default: begin    cr = rb;     cg = bottom; cb = rd;     end
         endcase
         d.red   = 8'(cr / FullCode);
         d.green = 8'(cg / FullCode);
         d.blue  = 8'(cb / FullCode);
      end
      return d;
   endfunction

   // ---------------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------------

   task automatic add_color(input cmd_type cmd, input int r, input int g, input int b,
                            input int h, input int v, input int s);
      color_word_type w;
      w.command = cmd;
      w.red     = 16'(r);
      w.green   = 16'(g);
      w.blue    = 16'(b);
      w.hue     = 9'(h);
      w.value   = 8'(v);
      w.sat     = 8'(s);
      pending_color_q.push_back(w);
   endtask

   // mix of in-range, just-over, negative and raw 16-bit levels
   function automatic logic signed [15:0] random_level();
      logic signed [15:0] lvl;
      case ($urandom_range(0, 5))
         0, 1: lvl = 16'($urandom_range(0, 255));
         2:    lvl = 16'($urandom_range(250, 300));
         3:    lvl = -16'($urandom_range(1, 300));
         4:    lvl = ($urandom_range(0, 1) != 0) ? 16'sh7fff : -16'sh8000;
         default: lvl = 16'($urandom);
      endcase
      return lvl;
   endfunction

   function automatic logic [7:0] random_component();
      logic [7:0] c;
      case ($urandom_range(0, 7))
         0: c = 8'd0;
         1: c = 8'd255;
         default: c = 8'($urandom_range(0, 255));
      endcase
      return c;
   endfunction

   task automatic add_random_colors(input int count);
      color_word_type w;
      for (int i = 0; i < count; i++) begin
         // unused fields of either mode carry random values too
         w.command = ($urandom_range(0, 1) != 0) ? CMD_HSV : CMD_RGB;
         w.red     = random_level();
         w.green   = random_level();
         w.blue    = random_level();
         case ($urandom_range(0, 9))
            0:       w.hue = 9'($urandom_range(361, 511));   // beyond a full turn
            1:       w.hue = 9'(SectorDegrees * $urandom_range(0, 6));  // sector edges
            default: w.hue = 9'($urandom_range(0, 360));
         endcase
         w.value = random_component();
         w.sat   = random_component();
         pending_color_q.push_back(w);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------------------------------

   color_word_type drive_word;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // the word on the port is taken at this edge: remember what it must give
         if (req_valid && req_ready) begin
            drive_word.command = cmd_type'(req_command);
            drive_word.red     = req_red_in;
            drive_word.green   = req_green_in;
            drive_word.blue    = req_blue_in;
            drive_word.hue     = req_hue;
            drive_word.value   = req_brightness;
            drive_word.sat     = req_saturation;
            expected_duty_q.push_back(predict_duty(drive_word));
         end
         // payload may only move once the port is empty or just accepted
         if (!req_valid || req_ready) begin
            if (pending_color_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               drive_word     = pending_color_q.pop_front();
               req_command    <= drive_word.command;
               req_red_in     <= drive_word.red;
               req_green_in   <= drive_word.green;
               req_blue_in    <= drive_word.blue;
               req_hue        <= drive_word.hue;
               req_brightness <= drive_word.value;
               req_saturation <= drive_word.sat;
               req_valid      <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // response monitor and checker
   // ---------------------------------------------------------------------------------------

   int       phase_seen;
   int       hold_left;
   duty_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         phase_seen <= 1;
         hold_left  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_duty_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MaxReports) begin
                  $display("[%0d] unexpected response word r=%0d g=%0d b=%0d", cycle_count,
                           rsp_red_duty, rsp_green_duty, rsp_blue_duty);
               end
            end else begin
               want = expected_duty_q.pop_front();
               if (rsp_red_duty !== want.red || rsp_green_duty !== want.green ||
                   rsp_blue_duty !== want.blue) begin
                  mismatch_count++;
                  if (mismatch_count <= MaxReports) begin
                     $display({"[%0d] duty mismatch: expected r=%0d g=%0d b=%0d,",
                               " got r=%0d g=%0d b=%0d"},
                              cycle_count, want.red, want.green, want.blue,
                              rsp_red_duty, rsp_green_duty, rsp_blue_duty);
                  end
               end
            end
         end
         // long hold-off at each phase change so the pipeline backs up into the request side
         if (phase != phase_seen) begin
            phase_seen <= phase;
            hold_left  <= HoldCycles;
            rsp_ready  <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // watchdog
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // stimulus sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // rgb: extremes, clamp boundaries, negative levels
      add_color(CMD_RGB, 0, 0, 0, 511, 255, 255);
      add_color(CMD_RGB, 255, 255, 255, 0, 0, 0);
      add_color(CMD_RGB, -32768, 32767, 256, 360, 128, 77);
      add_color(CMD_RGB, -1, 1, 254, 123, 200, 100);
      add_color(CMD_RGB, 32767, -32768, -256, 60, 1, 254);
      // hsv: every sector at its lower edge, upper edges of all sectors but those at 180 and 240
      add_color(CMD_HSV, -32768, 32767, -1, 0, 255, 255);
      add_color(CMD_HSV, 0, 0, 0, 59, 255, 255);
      add_color(CMD_HSV, 0, 0, 0, 60, 255, 255);
      add_color(CMD_HSV, 0, 0, 0, 119, 255, 255);
      add_color(CMD_HSV, 0, 0, 0, 120, 255, 255);
      add_color(CMD_HSV, 0, 0, 0, 179, 255, 255);
      add_color(CMD_HSV, 0, 0, 0, 180, 255, 255);
      add_color(CMD_HSV, 0, 0, 0, 240, 255, 255);
      add_color(CMD_HSV, 0, 0, 0, 300, 255, 255);
      add_color(CMD_HSV, 0, 0, 0, 359, 255, 255);
      // full turn and the hues beyond it
      add_color(CMD_HSV, 0, 0, 0, 360, 255, 255);
      add_color(CMD_HSV, 0, 0, 0, 361, 255, 255);
      add_color(CMD_HSV, 0, 0, 0, 420, 200, 180);
      add_color(CMD_HSV, 0, 0, 0, 480, 255, 255);
      add_color(CMD_HSV, 0, 0, 0, 511, 255, 255);
      // black, grey and mid values
      add_color(CMD_HSV, 100, 100, 100, 200, 0, 255);
      add_color(CMD_HSV, 0, 0, 0, 100, 255, 0);
      add_color(CMD_HSV, 0, 0, 0, 30, 128, 128);
      add_color(CMD_HSV, 0, 0, 0, 275, 1, 1);

      // phase 1: sender idles lightly, receiver heavily
      add_random_colors(450);
      while (pending_color_q.size() > 0) @(posedge clock);

      // phase 2: roles swapped
      send_idle_pct <= 72;
      recv_idle_pct <= 30;
      phase         <= 2;
      add_random_colors(500);
      while (pending_color_q.size() > 0) @(posedge clock);

      // phase 3: full rate both ways once the phase-change hold-off ends
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      phase         <= 3;
      add_random_colors(500);

      while (pending_color_q.size() > 0 || req_valid || expected_duty_q.size() > 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0 && expected_duty_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
